// File: hdl/gwm_pkg.sv
// shared types, character codes and folding for the glob wildcard matcher
package gwm_pkg;

  typedef enum logic [1:0] {
    MODE_PAT_APPEND = 2'd0,
    MODE_NAME_CHAR  = 2'd1,
    MODE_NAME_END   = 2'd2,
    MODE_PAT_CLEAR  = 2'd3
  } mode_e;

  localparam logic [7:0] CH_ANY   = 8'h3F;  // '?'
  localparam logic [7:0] CH_RUN   = 8'h2A;  // '*'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UZ    = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'

  // fold upper-case ascii letters to lower case, all other bytes pass
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UA && c <= CH_UZ) begin
      r = c + (CH_LA - CH_UA);
    end
    return r;
  endfunction

endpackage

// File: hdl/gwm_closure.sv
// star closure of the active position set as a parallel prefix network
module gwm_closure #(
  parameter int Positions = 32
) (
  input  logic [Positions:0]   set_i,
  input  logic [Positions-1:0] prop_i,
  output logic [Positions:0]   closed_o
);

  localparam int Levels = $clog2(Positions + 1);

  // gen: bit reachable, pass: every star between a span start and this bit
  logic [Positions:0] gen_lvl  [0:Levels];
  logic [Positions:0] pass_lvl [0:Levels];

  always_comb begin
    int span;
    gen_lvl[0]  = set_i;
    pass_lvl[0] = {prop_i, 1'b0};
    for (int lvl = 0; lvl < Levels; lvl++) begin
      span = 1 << lvl;
      for (int i = 0; i <= Positions; i++) begin
        if (i >= span) begin
          gen_lvl[lvl+1][i]  = gen_lvl[lvl][i] | (pass_lvl[lvl][i] & gen_lvl[lvl][i-span]);
          pass_lvl[lvl+1][i] = pass_lvl[lvl][i] & pass_lvl[lvl][i-span];
        end else begin
          gen_lvl[lvl+1][i]  = gen_lvl[lvl][i];
          pass_lvl[lvl+1][i] = 1'b0;
        end
      end
    end
  end

  assign closed_o = gen_lvl[Levels];

endmodule

// File: hdl/glob_wildcard_matcher.sv
// top level: streaming case-insensitive glob matcher with pattern store
// a name-end item passes the input stage register, then the result register, to valid_o
// throughput: one item per cycle while stall_o is low; all positions update in parallel
//   from the registered character, closure of runs of '*' is a log-depth prefix network
// reset: asynchronous active-low rst_ni clears pattern length, overflow flag, active set
//   (position zero only) and both valid flags; pattern bytes are not reset
module glob_wildcard_matcher #(
  parameter int PATTERN_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // item channel
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] symbol_i,
  // result channel
  output logic       valid_o,
  input  logic       stall_i,
  output logic       matched_o,
  output logic       overflow_o
);

  localparam int LenW = $clog2(PATTERN_MAX + 1);

  // input stage
  logic                 in_valid_q;
  gwm_pkg::mode_e       mode_q;
  logic [7:0]           sym_q;
  logic                 in_accept;
  logic                 advance;

  // pattern store: folded byte plus decoded wildcard flags per position
  logic [7:0]           chr_q  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] star_q;
  logic [PATTERN_MAX-1:0] any_q;
  logic                 store_we;

  // match state
  logic [LenW-1:0]      len_q, len_d;
  logic                 ovf_q, ovf_d;
  logic [PATTERN_MAX:0] active_q, active_d;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic                 matched_q, matched_d;
  logic                 overflow_q, overflow_d;

  // datapath
  logic [PATTERN_MAX-1:0] pos_valid;
  logic [PATTERN_MAX-1:0] star_prop;
  logic [PATTERN_MAX:0]   closed;
  logic [PATTERN_MAX:0]   stepped;
  logic [7:0]             sym_fold;
  logic                   full;

  // an end item may only leave the input stage when the result register frees up
  assign advance   = in_valid_q &
                     !(mode_q == gwm_pkg::MODE_NAME_END && out_valid_q && stall_i);
  assign stall_o   = in_valid_q & !advance;
  assign in_accept = valid_i & !stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= gwm_pkg::mode_e'(mode_i);
      sym_q  <= symbol_i;
    end
  end

  // positions below the loaded length take part in matching
  always_comb begin
    for (int p = 0; p < PATTERN_MAX; p++) begin
      pos_valid[p] = LenW'(p) < len_q;
    end
  end

  assign star_prop = star_q & pos_valid;
  assign full      = len_q == LenW'(PATTERN_MAX);
  assign sym_fold  = gwm_pkg::fold(sym_q);

  gwm_closure #(
    .Positions(PATTERN_MAX)
  ) u_closure (
    .set_i   (active_q),
    .prop_i  (star_prop),
    .closed_o(closed)
  );

  // one name character: a star keeps its position, others step forward on a hit
  always_comb begin
    stepped = '0;
    for (int p = 0; p < PATTERN_MAX; p++) begin
      if (closed[p] && pos_valid[p]) begin
        if (star_q[p]) begin
          stepped[p] = 1'b1;
        end else if (any_q[p]) begin
          if (sym_q != gwm_pkg::CH_SLASH) begin
            stepped[p+1] = 1'b1;
          end
        end else if (chr_q[p] == sym_fold) begin
          stepped[p+1] = 1'b1;
        end
      end
    end
  end

  // state update for the item leaving the input stage
  always_comb begin
    len_d    = len_q;
    ovf_d    = ovf_q;
    active_d = active_q;
    store_we = 1'b0;
    if (advance) begin
      unique case (mode_q)
        gwm_pkg::MODE_PAT_APPEND: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            store_we = 1'b1;
            len_d    = len_q + LenW'(1);
          end
        end
        gwm_pkg::MODE_NAME_CHAR: begin
          active_d = stepped;
        end
        gwm_pkg::MODE_NAME_END: begin
          active_d = {{PATTERN_MAX{1'b0}}, 1'b1};
        end
        gwm_pkg::MODE_PAT_CLEAR: begin
          len_d    = '0;
          ovf_d    = 1'b0;
          active_d = {{PATTERN_MAX{1'b0}}, 1'b1};
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end
  end

  // result register: loaded by a name end, drained by the downstream transfer
  always_comb begin
    out_valid_d = out_valid_q;
    matched_d   = matched_q;
    overflow_d  = overflow_q;
    if (out_valid_q && !stall_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && mode_q == gwm_pkg::MODE_NAME_END) begin
      out_valid_d = 1'b1;
      matched_d   = closed[len_q] & !ovf_q;
      overflow_d  = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      active_q    <= {{PATTERN_MAX{1'b0}}, 1'b1};
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q  <= matched_d;
    overflow_q <= overflow_d;
  end

  // pattern bytes land at the current length, stored pre-folded and decoded
  always_ff @(posedge clk_i) begin
    for (int p = 0; p < PATTERN_MAX; p++) begin
      if (store_we && len_q == LenW'(p)) begin
        chr_q[p]  <= sym_fold;
        star_q[p] <= sym_q == gwm_pkg::CH_RUN;
        any_q[p]  <= sym_q == gwm_pkg::CH_ANY;
      end
    end
  end

  assign valid_o    = out_valid_q;
  assign matched_o  = matched_q;
  assign overflow_o = overflow_q;

endmodule
